### rtl/core/lzwe_pkg.sv
// Shared constants, types and the probe hash for the 12-bit LZW encoder.
// Used by lzwe_dict, lzw_encoder_12bit_unit and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package lzwe_pkg;

  // Dictionary geometry
  localparam int DICT_ENTRIES      = 4096;
  localparam int MAX_STRING_LENGTH = 31;
  localparam int CODE_W            = $clog2(DICT_ENTRIES);
  localparam int BYTE_W            = 8;
  localparam int LEN_W             = $clog2(MAX_STRING_LENGTH + 1);
  // Hash table has twice as many slots as codes, so it stays under half full
  localparam int SLOT_W            = CODE_W + 1;
  localparam int SLOTS             = 2 ** SLOT_W;

  // Special codes
  localparam logic [CODE_W-1:0] FIRST_LEARNED = CODE_W'(256);
  localparam logic [CODE_W-1:0] END_MARKER    = CODE_W'(DICT_ENTRIES - 1);

  // Input item kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // One hash slot: the learned code and the pair it stands for
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] prefix;
    logic [BYTE_W-1:0] suffix;
  } slot_entry_t;

  // Learn request from the sequencer to the dictionary
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] prefix;
    logic [BYTE_W-1:0] suffix;
  } dict_wr_t;

  // Home slot of a (prefix, suffix) pair: byte folded into the top bits
  function automatic logic [SLOT_W-1:0] dict_hash(input logic [CODE_W-1:0] prefix,
                                                  input logic [BYTE_W-1:0] suffix);
    logic [SLOT_W-1:0] p;
    logic [SLOT_W-1:0] s;
    p = SLOT_W'(prefix);
    s = SLOT_W'(suffix) << (SLOT_W - BYTE_W);
    return p ^ s;
  endfunction

endpackage

### rtl/core/lzwe_dict.sv
// Dictionary storage for the LZW encoder: open-addressed hash table plus a
// back-pointer array from each learned code to its slot. Depends on lzwe_pkg.
`timescale 1ns / 1ps

module lzwe_dict (
  input  logic                        clk,
  input  logic [lzwe_pkg::SLOT_W-1:0] rd_slot,
  output lzwe_pkg::slot_entry_t       rd_entry,
  input  logic [lzwe_pkg::CODE_W-1:0] back_code,
  output logic [lzwe_pkg::SLOT_W-1:0] back_slot,
  input  lzwe_pkg::dict_wr_t          wr
);
  import lzwe_pkg::*;

  slot_entry_t       tab     [SLOTS];
  logic [SLOT_W-1:0] slot_of [DICT_ENTRIES];

  // Registered reads of both arrays
  always_ff @(posedge clk) begin
    rd_entry  <= tab[rd_slot];
    back_slot <= slot_of[back_code];
  end

  // Learn: fill the slot and point the new code back at it
  always_ff @(posedge clk) begin
    if (wr.en) begin
      tab[wr.slot]     <= '{code: wr.code, prefix: wr.prefix, suffix: wr.suffix};
      slot_of[wr.code] <= wr.slot;
    end
  end

endmodule

### rtl/core/lzw_encoder_12bit_unit.sv
// Top level of the 12-bit LZW encoder: match tracking, probe sequencer and
// output register. Depends on lzwe_pkg and lzwe_dict.
`timescale 1ns / 1ps

// The encoder takes one byte per transfer and returns dictionary codes.
// A data byte with a match pending is looked up by linear probing in a hash
// table of 2*DICT_ENTRIES slots; each probe is a table read, a back-pointer
// read and a decide step, and a slot held by another pair moves the probe on
// to the next slot. A new byte is taken only in idle, and the first byte of a
// stream opens the match with no probe. The table never passes half full, so
// probe chains stay short. A miss also loads the output register; an end item
// loads its pending code, if any, then the end marker, each waiting on out_ready.
// A slot counts as live only when its code lies in 256..next_free-1 and
// that code points back to the slot, so an end item discards the whole
// dictionary at once and no clearing pass is needed after reset.
module lzw_encoder_12bit_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [lzwe_pkg::BYTE_W-1:0] byte_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lzwe_pkg::CODE_W-1:0] code,
  output logic                        last
);
  import lzwe_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_MARK = 3'd5;

  logic [2:0]        state;
  logic [CODE_W-1:0] next_free;
  logic [CODE_W-1:0] match_code;
  logic [LEN_W-1:0]  match_length;
  logic              match_valid;
  logic [SLOT_W-1:0] slot_r;
  logic [BYTE_W-1:0] byte_r;
  logic [CODE_W-1:0] pend_code;
  logic              end_flag;
  logic              chk_range;
  logic              chk_eq;

  slot_entry_t       rd_entry;
  logic [SLOT_W-1:0] back_slot;
  dict_wr_t          wr;
  logic              probe_live;
  logic              learn_ok;
  logic              out_free;
  logic              out_load;
  logic              in_xfer;
  logic [CODE_W-1:0] byte_code;

  lzwe_dict u_dict (
    .clk       (clk),
    .rd_slot   (slot_r),
    .rd_entry  (rd_entry),
    .back_code (rd_entry.code),
    .back_slot (back_slot),
    .wr        (wr)
  );

  // Handshake and probe decisions
  assign in_ready   = (state == ST_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign out_load   = out_free && ((state == ST_EMIT) || (state == ST_MARK));
  assign byte_code  = CODE_W'(byte_r);
  assign probe_live = chk_range && (back_slot == slot_r);
  assign learn_ok   = (next_free < END_MARKER) &&
                      (match_length < LEN_W'(MAX_STRING_LENGTH));

  // Learn the pair into the empty slot that ended the probe
  always_comb begin
    wr.en     = (state == ST_DEC) && !probe_live && learn_ok;
    wr.slot   = slot_r;
    wr.code   = next_free;
    wr.prefix = match_code;
    wr.suffix = byte_r;
  end

  // Sequencer, match state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      next_free    <= FIRST_LEARNED;
      match_code   <= '0;
      match_length <= '0;
      match_valid  <= 1'b0;
      out_valid    <= 1'b0;
      end_flag     <= 1'b0;
    end else begin
      // Raise valid on a load, drop it after the transfer
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (kind == KIND_END) begin
              pend_code    <= match_code;
              end_flag     <= 1'b1;
              next_free    <= FIRST_LEARNED;
              match_code   <= '0;
              match_length <= '0;
              match_valid  <= 1'b0;
              state        <= match_valid ? ST_EMIT : ST_MARK;
            end else if (!match_valid) begin
              match_code   <= CODE_W'(byte_req);
              match_length <= LEN_W'(1);
              match_valid  <= 1'b1;
            end else begin
              byte_r <= byte_req;
              slot_r <= dict_hash(match_code, byte_req);
              state  <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          // a slot never written since power-up counts as not live
          if ((rd_entry.code >= FIRST_LEARNED) && (rd_entry.code < next_free)) begin
            chk_range <= 1'b1;
          end else begin
            chk_range <= 1'b0;
          end
          chk_eq    <= (rd_entry.prefix == match_code) && (rd_entry.suffix == byte_r);
          state     <= ST_DEC;
        end
        ST_DEC: begin
          if (probe_live) begin
            if (chk_eq) begin
              // hit: extend the match
              match_code   <= rd_entry.code;
              match_length <= match_length + LEN_W'(1);
              state        <= ST_IDLE;
            end else begin
              // slot held by another pair: advance
              slot_r <= slot_r + SLOT_W'(1);
              state  <= ST_RD;
            end
          end else begin
            // miss: emit current code, restart at the byte
            pend_code <= match_code;
            end_flag  <= 1'b0;
            if (learn_ok) begin
              next_free <= next_free + CODE_W'(1);
            end
            match_code   <= byte_code;
            match_length <= LEN_W'(1);
            state        <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            code      <= pend_code;
            last      <= 1'b0;
            state     <= end_flag ? ST_MARK : ST_IDLE;
          end
        end
        ST_MARK: begin
          if (out_free) begin
            code      <= END_MARKER;
            last      <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    (next_free >= FIRST_LEARNED) && (next_free <= END_MARKER))
    else $error("next_free out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && kind == KIND_END) |=> (!match_valid && next_free == FIRST_LEARNED))
    else $error("end item did not clear the dictionary");

  a_marker_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK && out_free) |=> (out_valid && last && code == END_MARKER))
    else $error("end marker not loaded");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    match_valid |-> (match_length != '0))
    else $error("pending match has zero length");
`endif

endmodule

### verif/tb_lzw_encoder_12bit_unit.sv
// Self-checking testbench for lzw_encoder_12bit_unit: directed rows, a run of
// one repeated byte, then streams of random bytes checked against an in-bench
// LZW dictionary predictor. Depends on lzwe_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module tb_lzw_encoder_12bit_unit;
  import lzwe_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_BYTES   = 1450;
  localparam int REPEAT_RUN     = 520;
  localparam int N_DIRECTED     = 24;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } code_word_t;

  typedef struct packed {
    logic              k;
    logic [BYTE_W-1:0] b;
    logic              typed;
    logic [1:0]        n;
    logic [CODE_W-1:0] c0;
    logic              l0;
    logic [CODE_W-1:0] c1;
    logic              l1;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              kind;
  logic [BYTE_W-1:0] byte_req;
  logic              out_valid;
  logic              out_ready;
  logic [CODE_W-1:0] code;
  logic              last;

  lzw_encoder_12bit_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .byte_req  (byte_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code      (code),
    .last      (last)
  );

  // Predictor state: learned pairs keyed by {prefix, suffix}
  logic [CODE_W-1:0] learned [bit [CODE_W+BYTE_W-1:0]];
  logic [CODE_W-1:0] free_code;
  logic [CODE_W-1:0] cur_code;
  logic [LEN_W-1:0]  cur_len;
  bit                cur_valid;

  code_word_t step_codes [$];
  code_word_t pending_codes [$];
  code_word_t want_word;
  stim_row_t  directed_rows [0:N_DIRECTED-1];

  int  errors;
  int  items_sent;
  int  streams_closed;
  int  hits;
  int  misses;
  int  length_refusals;
  int  full_refusals;
  int  codes_checked;
  int  idle_cycles;
  int  stall_left;
  bit  calm;

  // Clock
  initial clk = 1'b0;
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Idle length for either side: mostly none or short, a few long
  function automatic int idle_span();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the predictor by one accepted item; results land in step_codes
  task automatic encode_step(input logic k, input logic [BYTE_W-1:0] b);
    bit [CODE_W+BYTE_W-1:0] key;
    key = {cur_code, b};
    step_codes.delete();
    if (k == KIND_END) begin
      if (cur_valid) step_codes.push_back(code_word_t'{cur_code, 1'b0});
      step_codes.push_back(code_word_t'{END_MARKER, 1'b1});
      free_code = FIRST_LEARNED;
      cur_code  = '0;
      cur_len   = '0;
      cur_valid = 1'b0;
      learned.delete();
      streams_closed++;
    end else if (!cur_valid) begin
      // first byte of a stream opens the match
      cur_code  = CODE_W'(b);
      cur_len   = LEN_W'(1);
      cur_valid = 1'b1;
    end else if (learned.exists(key)) begin
      cur_code = learned[key];
      cur_len  = cur_len + LEN_W'(1);
      hits++;
    end else begin
      // miss: emit, learn if room and short enough, restart at the byte
      step_codes.push_back(code_word_t'{cur_code, 1'b0});
      misses++;
      if (free_code >= END_MARKER) begin
        full_refusals++;
      end else if (int'(cur_len) + 1 > MAX_STRING_LENGTH) begin
        length_refusals++;
      end else begin
        learned[key] = free_code;
        free_code    = free_code + CODE_W'(1);
      end
      cur_code = CODE_W'(b);
      cur_len  = LEN_W'(1);
    end
  endtask

  // Drive one item, wait for its transfer, and queue what it should produce
  task automatic send_item(input logic k, input logic [BYTE_W-1:0] b, input stim_row_t row);
    int gap;
    gap = idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      kind     <= 1'($urandom_range(0, 1));
      byte_req <= BYTE_W'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    byte_req <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
    encode_step(k, b);
    if (row.typed) begin
      if (row.n > 0) pending_codes.push_back(code_word_t'{row.c0, row.l0});
      if (row.n > 1) pending_codes.push_back(code_word_t'{row.c1, row.l1});
    end else begin
      foreach (step_codes[i]) pending_codes.push_back(step_codes[i]);
    end
    @(negedge clk);
  endtask

  // Hold off the sender until every expected code has arrived
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      if ($urandom_range(0, 99) < 30) stall_left = idle_span();
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each code transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected code: expected none, got code %h last %b",
                 $time, code, last);
        errors++;
      end else begin
        want_word = pending_codes.pop_front();
        codes_checked++;
        if (code !== want_word.code) begin
          $display("%0t: code mismatch: expected %h, got %h", $time, want_word.code, code);
          errors++;
        end
        if (last !== want_word.last) begin
          $display("%0t: last mismatch: expected %b, got %b", $time, want_word.last, last);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid === 1'b1 && in_ready === 1'b1) ||
        (out_valid === 1'b1 && out_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d codes outstanding", $time,
               pending_codes.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int               mask_pick;
    int               run_len;
    int               r;
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] fill;
    stim_row_t        no_row;

    rst       = 1'b1;
    in_valid  = 1'b0;
    kind      = KIND_DATA;
    byte_req  = '0;
    out_ready = 1'b0;
    calm      = 1'b0;
    no_row    = '0;
    errors = 0;
    items_sent = 0;
    streams_closed = 0;
    hits = 0;
    misses = 0;
    length_refusals = 0;
    full_refusals = 0;
    codes_checked = 0;
    free_code = FIRST_LEARNED;
    cur_code  = '0;
    cur_len   = '0;
    cur_valid = 1'b0;

    // kind, byte, typed, count, code0, last0, code1, last1
    directed_rows = '{
      '{KIND_END,  8'h00, 1'b1, 2'd1, END_MARKER,   1'b1, 12'h000, 1'b0}, // empty stream
      '{KIND_DATA, 8'h00, 1'b1, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0}, // first byte
      '{KIND_END,  8'hA5, 1'b1, 2'd2, 12'h000,      1'b0, END_MARKER, 1'b1},
      '{KIND_END,  8'hFF, 1'b1, 2'd1, END_MARKER,   1'b1, 12'h000, 1'b0},
      '{KIND_DATA, 8'hFF, 1'b1, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'hFF, 1'b1, 2'd1, 12'h0FF,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'hFF, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'hFF, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'h00, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'h01, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'h02, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'h04, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'h08, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'h10, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'h20, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'h40, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'h80, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'h55, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'hAA, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'h55, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'hAA, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_DATA, 8'h55, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_END,  8'h00, 1'b0, 2'd0, 12'h000,      1'b0, 12'h000, 1'b0},
      '{KIND_END,  8'h3C, 1'b1, 2'd1, END_MARKER,   1'b1, 12'h000, 1'b0}  // empty again
    };

    // Reset once
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(directed_rows[i].k, directed_rows[i].b, directed_rows[i]);
    end
    settle();

    // One byte repeated until matches hit the string length cap
    base = BYTE_W'($urandom_range(0, 255));
    repeat (REPEAT_RUN) send_item(KIND_DATA, base, no_row);
    send_item(KIND_END, BYTE_W'($urandom_range(0, 255)), no_row);
    settle();

    // Short streams over small alphabets so matches grow deep
    while (items_sent < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) run_len = 0;
      else if (r < 80) run_len = $urandom_range(1, 40);
      else run_len = $urandom_range(41, 200);
      // keep the last stream, end item included, inside the item budget
      if (run_len > RANDOM_BYTES - items_sent - 1) run_len = RANDOM_BYTES - items_sent - 1;
      mask_pick = $urandom_range(0, 5);
      case (mask_pick)
        0: mask = 8'h00;
        1: mask = 8'h01;
        2: mask = 8'h03;
        3: mask = 8'h07;
        4: mask = 8'h0F;
        default: mask = 8'hFF;
      endcase
      base = BYTE_W'($urandom_range(0, 255));
      for (int j = 0; j < run_len; j++) begin
        fill = base ^ (BYTE_W'($urandom_range(0, 255)) & mask);
        send_item(KIND_DATA, fill, no_row);
      end
      send_item(KIND_END, BYTE_W'($urandom_range(0, 255)), no_row);
      if ($urandom_range(0, 7) == 0) settle();
    end
    calm = 1'b0;
    settle();

    if (pending_codes.size() != 0) begin
      $display("%0t: %0d expected codes never arrived", $time, pending_codes.size());
      errors++;
    end

    $display("run: %0d items over %0d streams, %0d codes checked", items_sent,
             streams_closed, codes_checked);
    $display("run: %0d hits, %0d misses, %0d skipped at length cap, %0d with full dictionary",
             hits, misses, length_refusals, full_refusals);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
